/* hw/rtl/binaural_panner_filter_chain_assert.svh */
// Assertion macros for the binaural panner filter chain.
// Expect a clock named clk and a synchronous active-low reset named rst_n in scope.
`ifndef BINAURAL_PANNER_FILTER_CHAIN_ASSERT_SVH
`define BINAURAL_PANNER_FILTER_CHAIN_ASSERT_SVH

// same-cycle implication
`define BPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bpf_pkg.sv */
// Shared types, widths and helpers for the binaural panner filter chain.
// No dependencies.
package bpf_pkg;

  localparam int STATE_W         = 32;
  localparam int COEF_W          = 19;
  localparam int GAIN_W          = 17;
  localparam int ITD_W           = 7;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 19;
  localparam int FRAC_W          = 16;
  localparam int PROD_W          = COEF_W + STATE_W;
  localparam int ACC_W           = PROD_W + 2;
  localparam int RES_W           = ACC_W - FRAC_W;
  localparam int DEF_DELAY_DEPTH = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam logic [GAIN_W-1:0] ONE_Q16   = GAIN_W'(65536);
  localparam logic [FRAC_W-1:0] ROUND_LSB = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE, REG_LP, REG_B0, REG_B1, REG_A2, REG_GL, REG_GR, REG_ITD
  } cfg_idx_t;

  typedef struct packed {
    logic              mode;
    logic [GAIN_W-1:0] lp;
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] a2;
    logic [GAIN_W-1:0] gl;
    logic [GAIN_W-1:0] gr;
    logic [ITD_W-1:0]  itd;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic acc_en;
    logic sub;
  } mac_ctrl_t;

  function automatic logic [GAIN_W-1:0] clamp_q16(logic [GAIN_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(logic signed [RES_W-1:0] v);
    if ((&v[RES_W-1:STATE_W-1]) || !(|v[RES_W-1:STATE_W-1]))
      return v[STATE_W-1:0];
    else if (v[RES_W-1])
      return {1'b1, {(STATE_W-1){1'b0}}};
    else
      return {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

endpackage

/* hw/rtl/binaural_panner_filter_chain.sv */
// Binaural panner filter chain top level: sequencer around one shared MAC.
// Depends on bpf_pkg, bpf_cfg, bpf_mac, bpf_ring and the assertion header.
//
//  channel | ports                                   | dir
//  in      | in_valid, in_ready, in_sample_in        | sink
//  out     | out_valid, out_ready, out_left_out,     | source
//          | out_right_out                           |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// Each MAC step is a multiply state followed by an accumulate state. Binaural mode runs 14
// steps per item; pan mode runs 2 steps. All steps of an item run in turn on the single
// multiplier. in_ready is high only while idle; a finished item waits in the output
// register, and the next item may be taken meanwhile.
// Reset is synchronous; the delay memory needs no clearing pass.
module binaural_panner_filter_chain
  import bpf_pkg::*;
#(
  parameter int DELAY_DEPTH = DEF_DELAY_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

`include "binaural_panner_filter_chain_assert.svh"

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0]  ROUND_ACC = ACC_W'(32768);
  localparam logic signed [PROD_W:0]   ROUND_BX  = (PROD_W+1)'(32768);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_DONE} state_t;
  typedef enum logic [2:0] {OP_LPX, OP_LPZ, OP_B0, OP_B1X, OP_B1Y, OP_A2, OP_GAIN} op_t;

  state_t state_r;
  op_t    op_r;
  op_t    op_nxt;
  logic   ear_r;
  logic   ear_nxt;
  logic   last_step;

  cfg_t   cfg;

  logic signed [SB-1:0]      x_r;
  logic signed [STATE_W-1:0] t_r;
  logic signed [STATE_W-1:0] z_r  [2];
  logic signed [STATE_W-1:0] s0_r [2];
  logic signed [STATE_W-1:0] s1_r [2];
  logic signed [SB-1:0]      y_r  [2];
  logic signed [SB-1:0]      res_r [2];
  logic signed [PROD_W:0]    bx_r;
  logic                      out_valid_r;
  logic signed [SB-1:0]      out_left_r;
  logic signed [SB-1:0]      out_right_r;

  mac_ctrl_t                 mac_ctrl;
  logic signed [COEF_W-1:0]  mac_coef;
  logic signed [STATE_W-1:0] mac_opnd;
  logic signed [ACC_W-1:0]   mac_bias;
  logic signed [PROD_W-1:0]  mac_prod;
  logic signed [RES_W-1:0]   mac_res;
  logic                      load_sel;
  logic                      sub_sel;

  logic                      ring_rd_en;
  logic                      ring_wr_en;
  logic [ITD_W-1:0]          itd_mag;
  logic [2*SB-1:0]           ring_rd;
  logic                      left_dly;
  logic                      right_dly;
  logic signed [SB-1:0]      v_left;
  logic signed [SB-1:0]      v_right;
  logic signed [SB-1:0]      smp_sat;
  logic signed [STATE_W-1:0] st_sat;
  logic                      in_acc;

  bpf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpf_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .coef (mac_coef),
    .opnd (mac_opnd),
    .bias (mac_bias),
    .prod (mac_prod),
    .res  (mac_res)
  );

  bpf_ring #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ring_rd_en),
    .rd_mag  (itd_mag),
    .wr_en   (ring_wr_en),
    .wr_data ({y_r[1], y_r[0]}),
    .rd_data (ring_rd)
  );

  assign in_ready      = (state_r == ST_IDLE);
  assign in_acc        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  // positive delay holds back the left ear, negative the right
  assign right_dly  = cfg.itd[ITD_W-1];
  assign left_dly   = !cfg.itd[ITD_W-1] && (|cfg.itd);
  assign itd_mag    = right_dly ? ITD_W'(-$signed(cfg.itd)) : cfg.itd;
  assign ring_rd_en = in_acc && cfg.mode;
  assign ring_wr_en = (state_r == ST_ACC) && (op_r == OP_GAIN) && !ear_r && cfg.mode;

  assign v_left  = !cfg.mode ? x_r : (left_dly  ? ring_rd[SB-1:0]    : y_r[0]);
  assign v_right = !cfg.mode ? x_r : (right_dly ? ring_rd[2*SB-1:SB] : y_r[1]);

  assign st_sat = sat32(mac_res);

  always_comb begin
    if ((&mac_res[RES_W-1:SB-1]) || !(|mac_res[RES_W-1:SB-1]))
      smp_sat = mac_res[SB-1:0];
    else if (mac_res[RES_W-1])
      smp_sat = {1'b1, {(SB-1){1'b0}}};
    else
      smp_sat = {1'b0, {(SB-1){1'b1}}};
  end

  always_comb begin
    mac_coef = '0;
    mac_opnd = '0;
    mac_bias = ROUND_ACC;
    load_sel = 1'b1;
    sub_sel  = 1'b0;
    unique case (op_r)
      OP_LPX: begin
        mac_coef = {2'b00, cfg.lp};
        mac_opnd = STATE_W'(x_r);
      end
      OP_LPZ: begin
        mac_coef = COEF_W'(ONE_Q16) - {2'b00, cfg.lp};
        mac_opnd = z_r[ear_r];
        load_sel = 1'b0;
      end
      OP_B0: begin
        mac_coef = cfg.b0;
        mac_opnd = t_r;
        mac_bias = ACC_W'($signed({s0_r[ear_r], ROUND_LSB}));
      end
      OP_B1X: begin
        mac_coef = cfg.b1;
        mac_opnd = t_r;
        mac_bias = ACC_W'($signed({s1_r[ear_r], ROUND_LSB}));
      end
      OP_B1Y: begin
        mac_coef = cfg.b1;
        mac_opnd = STATE_W'(y_r[ear_r]);
        load_sel = 1'b0;
        sub_sel  = 1'b1;
      end
      OP_A2: begin
        mac_coef = cfg.a2;
        mac_opnd = STATE_W'(y_r[ear_r]);
        mac_bias = ACC_W'(bx_r);
        sub_sel  = 1'b1;
      end
      OP_GAIN: begin
        mac_coef = ear_r ? {2'b00, cfg.gr} : {2'b00, cfg.gl};
        mac_opnd = ear_r ? STATE_W'(v_right) : STATE_W'(v_left);
      end
      default: ;
    endcase
    mac_ctrl.load   = (state_r == ST_MUL) && load_sel;
    mac_ctrl.acc_en = (state_r == ST_ACC);
    mac_ctrl.sub    = sub_sel;
  end

  always_comb begin
    op_nxt    = op_r;
    ear_nxt   = ear_r;
    last_step = 1'b0;
    unique case (op_r)
      OP_LPX:  op_nxt = OP_LPZ;
      OP_LPZ:  op_nxt = OP_B0;
      OP_B0:   op_nxt = OP_B1X;
      OP_B1X:  op_nxt = OP_B1Y;
      OP_B1Y:  op_nxt = OP_A2;
      OP_A2: begin
        op_nxt  = ear_r ? OP_GAIN : OP_LPX;
        ear_nxt = !ear_r;
      end
      OP_GAIN: begin
        ear_nxt   = 1'b1;
        last_step = ear_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_LPX;
      ear_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int e = 0; e < 2; e++) begin
        z_r[e]  <= '0;
        s0_r[e] <= '0;
        s1_r[e] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            x_r     <= in_sample_in;
            op_r    <= cfg.mode ? OP_LPX : OP_GAIN;
            ear_r   <= 1'b0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: state_r <= ST_ACC;
        ST_ACC: begin
          case (op_r)
            OP_LPZ: begin
              z_r[ear_r] <= st_sat;
              t_r        <= st_sat;
            end
            OP_B0: begin
              y_r[ear_r] <= smp_sat;
              bx_r       <= (PROD_W+1)'(mac_prod) + ROUND_BX;
            end
            OP_B1Y:  s0_r[ear_r]  <= st_sat;
            OP_A2:   s1_r[ear_r]  <= st_sat;
            OP_GAIN: res_r[ear_r] <= smp_sat;
            default: ;
          endcase
          op_r    <= op_nxt;
          ear_r   <= ear_nxt;
          state_r <= last_step ? ST_DONE : ST_MUL;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_left_r  <= res_r[0];
            out_right_r <= res_r[1];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `BPF_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready, !in_ready, "ready after item taken")
  `BPF_ASSERT_NEXT(a_ring_one_write, ring_wr_en, !ring_wr_en, "ring written twice in a row")
  `BPF_ASSERT_NEXT(a_done_delivers, (state_r == ST_DONE) && (!out_valid_r || out_ready), out_valid_r && in_ready, "finished item not delivered")
  `BPF_ASSERT_NOW(a_ring_wr_binaural, ring_wr_en, cfg.mode && (state_r == ST_ACC), "ring written outside binaural step")

endmodule

/* hw/rtl/bpf_cfg.sv */
// Configuration register file for the binaural panner filter chain.
// Depends on bpf_pkg.
module bpf_cfg
  import bpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= 1'b1;
      cfg_r.lp   <= ONE_Q16;
      cfg_r.b0   <= COEF_W'(65536);
      cfg_r.b1   <= '0;
      cfg_r.a2   <= '0;
      cfg_r.gl   <= ONE_Q16;
      cfg_r.gr   <= ONE_Q16;
      cfg_r.itd  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MODE: cfg_r.mode <= cfg_data[0];
        REG_LP:   cfg_r.lp   <= clamp_q16(cfg_data[GAIN_W-1:0]);
        REG_B0:   cfg_r.b0   <= cfg_data[COEF_W-1:0];
        REG_B1:   cfg_r.b1   <= cfg_data[COEF_W-1:0];
        REG_A2:   cfg_r.a2   <= cfg_data[COEF_W-1:0];
        REG_GL:   cfg_r.gl   <= clamp_q16(cfg_data[GAIN_W-1:0]);
        REG_GR:   cfg_r.gr   <= clamp_q16(cfg_data[GAIN_W-1:0]);
        REG_ITD:  cfg_r.itd  <= cfg_data[ITD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/bpf_mac.sv */
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on bpf_pkg.
module bpf_mac
  import bpf_pkg::*;
(
  input  logic                      clk,
  input  mac_ctrl_t                 ctrl,
  input  logic signed [COEF_W-1:0]  coef,
  input  logic signed [STATE_W-1:0] opnd,
  input  logic signed [ACC_W-1:0]   bias,
  output logic signed [PROD_W-1:0]  prod,
  output logic signed [RES_W-1:0]   res
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod_r);
  assign acc_nxt  = ctrl.sub ? (acc_r - prod_ext) : (acc_r + prod_ext);
  assign prod     = prod_r;
  assign res      = acc_nxt[ACC_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    prod_r <= coef * opnd;
    if (ctrl.load) begin
      acc_r <= bias;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

/* hw/rtl/bpf_ring.sv */
// Interaural delay memory, both ears in one word, with a fill count.
// Depends on bpf_pkg.
module bpf_ring
  import bpf_pkg::*;
#(
  parameter int DELAY_DEPTH = DEF_DELAY_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [ITD_W-1:0]         rd_mag,
  input  logic                     wr_en,
  input  logic [2*SAMPLE_BITS-1:0] wr_data,
  output logic [2*SAMPLE_BITS-1:0] rd_data
);

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int CNT_W = $clog2(DELAY_DEPTH + 1);
  localparam int CMP_W = CNT_W + ITD_W;
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DELAY_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W+1)'(DELAY_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DELAY_DEPTH);
  localparam logic [AW-1:0]    LAST_IDX  = AW'(DELAY_DEPTH - 1);

  logic [2*SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic [2*SAMPLE_BITS-1:0] q_r;
  logic                     hit_r;
  logic [AW-1:0]            wr_ptr_r;
  logic [CNT_W-1:0]         fill_r;
  logic [CMP_W-1:0]         mag_ext;
  logic [CNT_W-1:0]         dly_len;
  logic [CNT_W:0]           sum;
  logic [AW-1:0]            raddr;

  assign mag_ext = CMP_W'(rd_mag);
  assign dly_len = (mag_ext > DEPTH_CMP) ? DEPTH_CNT : mag_ext[CNT_W-1:0];
  assign sum     = (CNT_W+1)'(wr_ptr_r) + DEPTH_SUM - (CNT_W+1)'(dly_len);
  assign raddr   = (sum >= DEPTH_SUM) ? AW'(sum - DEPTH_SUM) : AW'(sum);
  assign rd_data = hit_r ? q_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
      hit_r    <= 1'b0;
    end else begin
      if (rd_en) begin
        hit_r <= (dly_len <= fill_r);
      end
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
        if (fill_r != DEPTH_CNT) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

endmodule
